>>> rtl/ack_pkg.sv
// Shared constants, types and mod-26 helpers for the autokey cipher unit.
`timescale 1ns / 1ps
package ack_pkg;

   localparam int KEY_DEPTH = 64;
   localparam int KEY_IDX_W = $clog2(KEY_DEPTH);
   localparam int KEY_CNT_W = $clog2(KEY_DEPTH + 1);
   localparam int LETTER_W  = 5;
   localparam int CHAR_W    = 8;
   localparam int KIND_W    = 2;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TEXT    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

   localparam logic [1:0] REG_AUTOKEY_MODE = 2'd0;
   localparam logic [1:0] REG_DECRYPT_MODE = 2'd1;
   localparam logic [1:0] REG_SHIFT_AMOUNT = 2'd2;

   localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'd65;
   localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'd90;
   localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'd97;
   localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'd122;
   localparam logic [CHAR_W-1:0] CASE_OFFSET   = 8'd32;
   localparam logic [LETTER_W:0] ALPHA_LEN     = 6'd26;

   typedef logic [LETTER_W-1:0] letter_type;

   typedef struct packed {
      logic       pop;
      logic       push;
      logic       clear;
      letter_type push_data;
   } key_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } key_status_type;

   function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
         r = c - CASE_OFFSET;
      end
      return r;
   endfunction

   function automatic letter_type add_mod26(input letter_type a, input letter_type b);
      logic [LETTER_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= ALPHA_LEN) begin
         s = s - ALPHA_LEN;
      end
      return s[LETTER_W-1:0];
   endfunction

   function automatic letter_type neg_mod26(input letter_type a);
      logic [LETTER_W:0] s;
      s = ALPHA_LEN - {1'b0, a};
      if (a == '0) begin
         s = '0;
      end
      return s[LETTER_W-1:0];
   endfunction

endpackage

>>> rtl/autokey_caesar_cipher_unit.sv
// Top level of the autokey / shift cipher unit: CSRs, cipher datapath and output stage.
//
// channel  direction  handshake              payload
// req      in         req_tvalid/req_tready  tdata: char_in[7:0]; tuser: kind[1:0]
// rsp      out        rsp_tvalid/rsp_tready  tdata: out_char[7:0]
// csr      in         csr_psel/csr_penable   paddr 4 bits, registers at 0x0, 0x4, 0x8
//
// One item per cycle while the output register is empty or being taken; a text item's result
// is registered and appears in the cycle after it is accepted. The mod-26 add and the key queue
// pop and push both happen in the accepting cycle; the queue head always sits in cell zero of the cell row.
// Reset clears the CSRs, the queue count and the output valid flag; no clearing pass.
// A stalled result holds in the output register; req_tready stays high while it is taken.
`timescale 1ns / 1ps
module autokey_caesar_cipher_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ack_pkg::CHAR_W-1:0]      req_tdata,   // [7:0] char_in
   input  logic [ack_pkg::KIND_W-1:0]      req_tuser,   // [1:0] kind
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ack_pkg::CHAR_W-1:0]      rsp_tdata,   // [7:0] out_char
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ack_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ack_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ack_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import ack_pkg::*;

   logic              autokey_ff;
   logic              decrypt_ff;
   logic [4:0]        shift_ff;
   logic              csr_write;

   logic              accept;
   logic [CHAR_W-1:0] upper;
   logic              is_letter;
   letter_type        p;
   letter_type        n;
   letter_type        key;
   letter_type        r;
   logic [CHAR_W-1:0] result;

   key_ctl_type       ctl;
   key_status_type    status;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [CHAR_W-1:0] rsp_data_ff;
   logic [CHAR_W-1:0] rsp_data_in;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         autokey_ff <= 1'b0;
         decrypt_ff <= 1'b0;
         shift_ff   <= '0;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_AUTOKEY_MODE: autokey_ff <= csr_pwdata[0];
            REG_DECRYPT_MODE: decrypt_ff <= csr_pwdata[0];
            REG_SHIFT_AMOUNT: shift_ff   <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_AUTOKEY_MODE: csr_prdata = CSR_DATA_W'(autokey_ff);
         REG_DECRYPT_MODE: csr_prdata = CSR_DATA_W'(decrypt_ff);
         REG_SHIFT_AMOUNT: csr_prdata = CSR_DATA_W'(shift_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // cipher datapath
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign upper      = to_upper(req_tdata);
   assign is_letter  = (upper >= ASCII_UPPER_A) && (upper <= ASCII_UPPER_Z);
   assign p          = LETTER_W'(upper - ASCII_UPPER_A);
   assign n          = ({1'b0, shift_ff} >= ALPHA_LEN) ? LETTER_W'({1'b0, shift_ff} - ALPHA_LEN)
                                                       : shift_ff;

   always_comb begin
      if (!autokey_ff) begin
         r = decrypt_ff ? add_mod26(p, neg_mod26(n)) : add_mod26(p, n);
      end else begin
         r = decrypt_ff ? add_mod26(p, add_mod26(neg_mod26(key), n))
                        : add_mod26(p, add_mod26(key, neg_mod26(n)));
      end
   end

   always_comb begin
      result = ASCII_UPPER_A + CHAR_W'(r);
      if (!is_letter || (autokey_ff && status.empty)) begin
         result = upper;
      end
   end

   always_comb begin
      ctl.clear     = accept && (req_tuser == KIND_RESTART);
      ctl.pop       = accept && (req_tuser == KIND_TEXT) && is_letter && autokey_ff
                      && !status.empty;
      ctl.push      = ctl.pop
                      || (accept && (req_tuser == KIND_LOAD) && is_letter && !status.full);
      ctl.push_data = (ctl.pop && decrypt_ff) ? r : p;
   end

   ack_key_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .head_data (key),
      .status    (status)
   );

   // output stage
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (accept && (req_tuser == KIND_TEXT)) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/ack_key_cell.sv
// One stage of the key queue: holds a key letter, shifts from its neighbor or loads a push.
`timescale 1ns / 1ps
module ack_key_cell (
   input  logic                clock,
   input  logic                pop,
   input  logic                load,
   input  ack_pkg::letter_type load_data,
   input  ack_pkg::letter_type next_data,
   output ack_pkg::letter_type data
);
   import ack_pkg::*;

   letter_type data_ff;
   letter_type data_in;

   always_comb begin
      data_in = data_ff;
      if (load) begin
         data_in = load_data;
      end else if (pop) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

>>> rtl/ack_key_chain.sv
// Key queue built as a row of shifting cells with the head in cell zero.
`timescale 1ns / 1ps
module ack_key_chain (
   input  logic                    clock,
   input  logic                    reset,
   input  ack_pkg::key_ctl_type    ctl,
   output ack_pkg::letter_type     head_data,
   output ack_pkg::key_status_type status
);
   import ack_pkg::*;

   logic [KEY_CNT_W-1:0] count_ff;
   logic [KEY_CNT_W-1:0] count_in;
   logic [KEY_CNT_W-1:0] push_idx;
   letter_type           cell_data [KEY_DEPTH];

   assign push_idx = count_ff - KEY_CNT_W'(ctl.pop);

   genvar i;
   generate
      for (i = 0; i < KEY_DEPTH; i++) begin : g_cell
         letter_type next_data;
         logic       load;
         if (i == KEY_DEPTH - 1) begin : g_last
            assign next_data = '0;
         end else begin : g_mid
            assign next_data = cell_data[i+1];
         end
         assign load = ctl.push && (push_idx == KEY_CNT_W'(i));
         ack_key_cell u_cell (
            .clock     (clock),
            .pop       (ctl.pop),
            .load      (load),
            .load_data (ctl.push_data),
            .next_data (next_data),
            .data      (cell_data[i])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else begin
         count_in = count_ff + KEY_CNT_W'(ctl.push) - KEY_CNT_W'(ctl.pop);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head_data    = cell_data[0];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == KEY_CNT_W'(KEY_DEPTH));

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= KEY_CNT_W'(KEY_DEPTH))
      else $error("key queue count above depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |-> count_ff != '0)
      else $error("pop from empty key queue");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (ctl.push && !ctl.pop) |-> count_ff != KEY_CNT_W'(KEY_DEPTH))
      else $error("push into full key queue");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> count_ff == '0)
      else $error("restart left key queue occupied");

   a_pop_only_count: assert property (@(posedge clock) disable iff (reset)
      (ctl.pop && !ctl.push && !ctl.clear) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("key queue count did not drop on pop");

endmodule

>>> tb/autokey_caesar_cipher_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the autokey / shift cipher unit: directed rows, then random phases.
module autokey_caesar_cipher_unit_tb;
   import ack_pkg::*;

   localparam int RAND_ITEMS    = 1660;
   localparam int CALM_FROM     = RAND_ITEMS * 85 / 100;
   localparam int SETTLE_CYCLES = 4;
   localparam int STALL_LIMIT   = 1000;
   localparam int MAX_REPORTS   = 10;
   localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

   typedef enum {ROW_ITEM, ROW_CONFIG, ROW_FILL} row_op_e;

   typedef struct {
      row_op_e           op;
      logic [1:0]        sel;
      logic [CHAR_W-1:0] data;
      bit                typed;
      logic [CHAR_W-1:0] want;
   } stim_row_t;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [CHAR_W-1:0]     req_tdata;   // [7:0] char_in
   logic [KIND_W-1:0]     req_tuser;   // [1:0] kind
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [CHAR_W-1:0]     rsp_tdata;   // [7:0] out_char
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic                  row_typed;
   logic [CHAR_W-1:0]     row_want;

   bit                    cfg_autokey;
   bit                    cfg_decrypt;
   logic [4:0]            cfg_shift;
   letter_type            key_letters [KEY_DEPTH];
   logic [KEY_IDX_W-1:0]  key_head;
   logic [KEY_CNT_W-1:0]  key_fill;

   logic [CHAR_W-1:0]     expected_chars [$];
   int                    errors;
   int                    quiet_cycles;
   int                    items_sent;
   int                    gap_pct;
   int                    stall_pct;
   logic                  calm;
   logic [CHAR_W-1:0]     predicted;
   logic [CHAR_W-1:0]     oldest;
   bit                    active;

   assign calm = (items_sent >= CALM_FROM);

   autokey_caesar_cipher_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void store_key(input int letter);
      if (int'(key_fill) < KEY_DEPTH) begin
         key_letters[(int'(key_head) + int'(key_fill)) % KEY_DEPTH] = LETTER_W'(letter);
         key_fill = key_fill + 1'b1;
      end
   endfunction

   function automatic bit predict_cipher(input logic [KIND_W-1:0] kind,
                                         input logic [CHAR_W-1:0] raw,
                                         output logic [CHAR_W-1:0] res);
      logic [CHAR_W-1:0] c;
      bit                letter;
      int                n;
      int                p;
      int                k;
      int                r;
      c = (raw >= ASCII_LOWER_A && raw <= ASCII_LOWER_Z) ? raw - CASE_OFFSET : raw;
      letter = (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z);
      n = int'(cfg_shift) % int'(ALPHA_LEN);
      res = c;
      if (kind == KIND_RESTART) begin
         key_head = '0;
         key_fill = '0;
         return 1'b0;
      end
      if (kind == KIND_LOAD) begin
         if (letter) begin
            store_key(int'(c - ASCII_UPPER_A));
         end
         return 1'b0;
      end
      if (kind != KIND_TEXT) begin
         return 1'b0;
      end
      if (!letter) begin
         return 1'b1;
      end
      p = int'(c - ASCII_UPPER_A);
      if (!cfg_autokey) begin
         r = cfg_decrypt ? (p + int'(ALPHA_LEN) - n) % int'(ALPHA_LEN)
                         : (p + n) % int'(ALPHA_LEN);
      end else if (key_fill == '0) begin
         return 1'b1;
      end else begin
         k = int'(key_letters[key_head]);
         key_head = KEY_IDX_W'((int'(key_head) + 1) % KEY_DEPTH);
         key_fill = key_fill - 1'b1;
         if (cfg_decrypt) begin
            r = (p + int'(ALPHA_LEN) - k + n) % int'(ALPHA_LEN);
            store_key(r);
         end else begin
            r = (p + k + int'(ALPHA_LEN) - n) % int'(ALPHA_LEN);
            store_key(p);
         end
      end
      res = ASCII_UPPER_A + CHAR_W'(r);
      return 1'b1;
   endfunction

   function automatic logic [CHAR_W-1:0] rand_letter();
      return ($urandom_range(0, 1) ? ASCII_UPPER_A : ASCII_LOWER_A) + CHAR_W'($urandom_range(0, 25));
   endfunction

   task automatic note_error(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         active = csr_psel && csr_penable && csr_pwrite && csr_pready;
         if (req_tvalid && req_tready) begin
            active = 1'b1;
            if (predict_cipher(req_tuser, req_tdata, predicted)) begin
               expected_chars.push_back(row_typed ? row_want : predicted);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            active = 1'b1;
            if (expected_chars.size() == 0) begin
               note_error($sformatf("unexpected out_char 0x%02h", rsp_tdata));
            end else begin
               oldest = expected_chars.pop_front();
               if (rsp_tdata !== oldest) begin
                  note_error($sformatf("out_char expected 0x%02h actual 0x%02h",
                                       oldest, rsp_tdata));
               end
            end
         end
         quiet_cycles = active ? 0 : quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 99) < stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                            input bit typed = 1'b0, input logic [CHAR_W-1:0] want = '0);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= ch;
      row_typed  <= typed;
      row_want   <= want;
      do @(posedge clock); while (!req_tready);
      if (kind != KIND_IGNORED) begin
         items_sent++;
      end
      @(negedge clock);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_chars.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] sel, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (sel)
         REG_AUTOKEY_MODE: cfg_autokey = value[0];
         REG_DECRYPT_MODE: cfg_decrypt = value[0];
         REG_SHIFT_AMOUNT: cfg_shift = value[4:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   initial begin
      stim_row_t   rows [$];
      int          span;
      int          phase_end;
      logic [4:0]  shift_pick;

      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      row_typed    = 1'b0;
      row_want     = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      errors       = 0;
      quiet_cycles = 0;
      items_sent   = 0;
      gap_pct      = 12;
      stall_pct    = 12;
      cfg_autokey  = 1'b0;
      cfg_decrypt  = 1'b0;
      cfg_shift    = '0;
      key_head     = '0;
      key_fill     = '0;

      rows.push_back('{ROW_ITEM,   KIND_TEXT,        "a",    1'b1, "A"});
      rows.push_back('{ROW_ITEM,   KIND_TEXT,        8'h00,  1'b1, 8'h00});
      rows.push_back('{ROW_ITEM,   KIND_TEXT,        8'hff,  1'b1, 8'hff});
      rows.push_back('{ROW_ITEM,   KIND_TEXT,        "z",    1'b1, "Z"});
      rows.push_back('{ROW_ITEM,   KIND_IGNORED,     "A",    1'b0, 8'h00});
      rows.push_back('{ROW_ITEM,   KIND_LOAD,        "Q",    1'b0, 8'h00});
      rows.push_back('{ROW_ITEM,   KIND_RESTART,     8'hff,  1'b0, 8'h00});
      rows.push_back('{ROW_CONFIG, REG_SHIFT_AMOUNT, 8'd25,  1'b0, 8'h00});
      rows.push_back('{ROW_ITEM,   KIND_TEXT,        "A",    1'b1, "Z"});
      rows.push_back('{ROW_ITEM,   KIND_TEXT,        "@",    1'b1, "@"});
      rows.push_back('{ROW_CONFIG, REG_SHIFT_AMOUNT, 8'd31,  1'b0, 8'h00});
      rows.push_back('{ROW_ITEM,   KIND_TEXT,        "A",    1'b1, "F"});
      rows.push_back('{ROW_CONFIG, REG_DECRYPT_MODE, 8'd1,   1'b0, 8'h00});
      rows.push_back('{ROW_ITEM,   KIND_TEXT,        "A",    1'b1, "V"});
      rows.push_back('{ROW_CONFIG, REG_AUTOKEY_MODE, 8'd1,   1'b0, 8'h00});
      rows.push_back('{ROW_CONFIG, REG_DECRYPT_MODE, 8'd0,   1'b0, 8'h00});
      rows.push_back('{ROW_CONFIG, REG_SHIFT_AMOUNT, 8'd0,   1'b0, 8'h00});
      rows.push_back('{ROW_ITEM,   KIND_TEXT,        "M",    1'b1, "M"});
      rows.push_back('{ROW_ITEM,   KIND_LOAD,        "1",    1'b0, 8'h00});
      rows.push_back('{ROW_ITEM,   KIND_TEXT,        "b",    1'b1, "B"});
      rows.push_back('{ROW_ITEM,   KIND_LOAD,        "k",    1'b0, 8'h00});
      rows.push_back('{ROW_ITEM,   KIND_TEXT,        "C",    1'b1, "M"});
      rows.push_back('{ROW_ITEM,   KIND_TEXT,        "A",    1'b1, "C"});
      rows.push_back('{ROW_ITEM,   KIND_RESTART,     8'h00,  1'b0, 8'h00});
      rows.push_back('{ROW_CONFIG, REG_DECRYPT_MODE, 8'd1,   1'b0, 8'h00});
      rows.push_back('{ROW_CONFIG, REG_SHIFT_AMOUNT, 8'd3,   1'b0, 8'h00});
      rows.push_back('{ROW_ITEM,   KIND_LOAD,        "Z",    1'b0, 8'h00});
      rows.push_back('{ROW_ITEM,   KIND_TEXT,        "A",    1'b1, "E"});
      rows.push_back('{ROW_ITEM,   KIND_TEXT,        "y",    1'b0, 8'h00});
      rows.push_back('{ROW_FILL,   KIND_LOAD,        8'h00,  1'b0, 8'h00});
      rows.push_back('{ROW_ITEM,   KIND_TEXT,        "Q",    1'b0, 8'h00});
      rows.push_back('{ROW_ITEM,   KIND_TEXT,        "!",    1'b1, "!"});
      rows.push_back('{ROW_ITEM,   KIND_IGNORED,     8'h00,  1'b0, 8'h00});
      rows.push_back('{ROW_ITEM,   KIND_TEXT,        "x",    1'b0, 8'h00});
      rows.push_back('{ROW_CONFIG, REG_DECRYPT_MODE, 8'd0,   1'b0, 8'h00});
      rows.push_back('{ROW_ITEM,   KIND_TEXT,        "N",    1'b0, 8'h00});
      rows.push_back('{ROW_ITEM,   KIND_LOAD,        "E",    1'b0, 8'h00});
      rows.push_back('{ROW_ITEM,   KIND_TEXT,        "z",    1'b0, 8'h00});

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (rows[i]) begin
         case (rows[i].op)
            ROW_ITEM: send_item(rows[i].sel, rows[i].data, rows[i].typed, rows[i].want);
            ROW_CONFIG: begin
               settle();
               write_csr(rows[i].sel, CSR_DATA_W'(rows[i].data));
            end
            ROW_FILL: begin
               repeat (KEY_DEPTH + 2) send_item(KIND_LOAD, rand_letter());
            end
            default: ;
         endcase
      end

      items_sent = 0;
      while (items_sent < RAND_ITEMS) begin
         settle();
         case ($urandom_range(0, 3))
            0: shift_pick = 5'd0;
            1: shift_pick = 5'd25;
            2: shift_pick = 5'd31;
            default: shift_pick = 5'($urandom_range(0, 31));
         endcase
         write_csr(REG_AUTOKEY_MODE, CSR_DATA_W'($urandom_range(0, 9) < 7));
         write_csr(REG_DECRYPT_MODE, CSR_DATA_W'($urandom_range(0, 1)));
         write_csr(REG_SHIFT_AMOUNT, CSR_DATA_W'(shift_pick));
         gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : 12;
         stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 12;
         phase_end = items_sent + $urandom_range(80, 200);
         while (items_sent < phase_end && items_sent < RAND_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
               if ($urandom_range(0, 3) != 0) begin
                  send_item(KIND_RESTART, CHAR_W'($urandom_range(0, 255)));
               end
               span = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 12);
               repeat (span) begin
                  send_item(KIND_LOAD, ($urandom_range(0, 9) != 0) ? rand_letter()
                                                                   : CHAR_W'($urandom_range(0, 255)));
               end
               span = $urandom_range(4, 40);
               repeat (span) begin
                  send_item(KIND_TEXT, ($urandom_range(0, 4) != 0) ? rand_letter()
                                                                   : CHAR_W'($urandom_range(0, 255)));
               end
            end else begin
               repeat ($urandom_range(1, 10)) begin
                  send_item(KIND_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)));
               end
            end
         end
      end

      settle();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
